// ===== design/knn_top_k_classifier_defines.svh =====
// assertion macros for the knn classifier top level
// no dependencies; pulled in by the top level with an include
`ifndef KNN_TOP_K_CLASSIFIER_DEFINES_SVH
`define KNN_TOP_K_CLASSIFIER_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define KNN_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define KNN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/knn_pkg.sv =====
// types, sizes and codes for the knn top-k classifier
// no dependencies; imported by knn_top_k_classifier
package knn_pkg;

    localparam int MAX_FEATURES = 64;
    localparam int MAX_K        = 16;
    localparam int MAX_CLASSES  = 16;

    localparam int FEAT_IDX_W = 6;
    localparam int FEAT_W     = 16;
    localparam int CLASS_W    = 4;
    localparam int NF_W       = 7;
    localparam int K_W        = 5;
    localparam int NC_W       = 5;
    localparam int CNT_W      = 5;
    localparam int DIST_W     = 40;
    localparam int MAG_W      = FEAT_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam int SLOT_W = $clog2(MAX_K);
    localparam int CLS_W  = $clog2(MAX_CLASSES);
    localparam int IDX_W  = (SLOT_W > CLS_W) ? SLOT_W : CLS_W;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [CNT_W-1:0]  VOTE_MAX = '1;

    typedef enum logic [1:0] {
        KIND_TEST     = 2'd0,
        KIND_TRAIN    = 2'd1,
        KIND_END      = 2'd2,
        KIND_CLASSIFY = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_FEATURES = 2'd0,
        CFG_K_USED       = 2'd1,
        CFG_NUM_CLASSES  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ACC,
        S_CNT,
        S_VOTE
    } t_state;

    typedef struct packed {
        t_kind                     kind;
        logic [FEAT_IDX_W-1:0]     feature_index;
        logic signed [FEAT_W-1:0]  feature_value;
        logic [CLASS_W-1:0]        sample_label;
    } t_item;

    typedef struct packed {
        logic [CLASS_W-1:0] predicted_class;
        logic               no_prediction;
        logic [CNT_W-1:0]   neighbors_found;
    } t_result;

endpackage

// ===== design/knn_top_k_classifier.sv =====
// knn top-k classifier: distance accumulation, sorted neighbor list, vote
// test feature, end-of-sample and out-of-range training items leave busy low; a training
// feature keeps busy high through the square and add states after the memory read at its
// accept edge; classify keeps busy high through a scan of the k_used slots, then of the
// num_classes votes (both clamped), result strobe in the first cycle with busy low again; receiver cannot stall
// reset (i_rst_n low, synchronous) empties the list, clears the sum, loads register defaults
`include "knn_top_k_classifier_defines.svh"

module knn_top_k_classifier
    import knn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  start,
    output logic                  busy,
    input  t_item                 i_item,
    // result channel, one-cycle strobe
    output logic                  o_res_valid,
    output t_result               o_res,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    t_state                   r_state,    n_state;
    logic [NF_W-1:0]          r_nf,       n_nf;
    logic [K_W-1:0]           r_k,        n_k;
    logic [NC_W-1:0]          r_nc,       n_nc;

    // running squared distance of the sample being streamed
    logic [DIST_W-1:0]        r_acc,      n_acc;
    logic signed [FEAT_W-1:0] r_val,      n_val;
    logic [SQ_W-1:0]          r_sq,       n_sq;

    // sorted neighbor list, nearest in slot 0
    logic [DIST_W-1:0]        r_dist   [MAX_K];
    logic [DIST_W-1:0]        n_dist   [MAX_K];
    logic [CLASS_W-1:0]       r_cls    [MAX_K];
    logic [CLASS_W-1:0]       n_cls    [MAX_K];
    logic [MAX_K-1:0]         r_filled,   n_filled;

    // vote counters and scan state
    logic [CNT_W-1:0]         r_vote   [MAX_CLASSES];
    logic [CNT_W-1:0]         n_vote   [MAX_CLASSES];
    logic [IDX_W-1:0]         r_idx,      n_idx;
    logic [CNT_W-1:0]         r_found,    n_found;
    logic [CLS_W-1:0]         r_best,     n_best;
    logic [CNT_W-1:0]         r_best_n,   n_best_n;

    t_result                  r_res,      n_res;
    logic                     r_res_valid, n_res_valid;

    // test vector store, one write or one read per cycle, registered read data
    logic signed [FEAT_W-1:0] r_tv_mem [MAX_FEATURES];
    logic signed [FEAT_W-1:0] r_tv_q;

    // ---------------------------------------------------------------
    // handshakes and clamped registers
    // ---------------------------------------------------------------
    logic                     w_accept;
    logic                     w_cfg_we;
    logic [NF_W-1:0]          w_nf_eff;
    logic [K_W-1:0]           w_k_eff;
    logic [NC_W-1:0]          w_nc_eff;
    logic [IDX_W-1:0]         w_k_last;
    logic [IDX_W-1:0]         w_nc_last;
    logic                     w_train_ok;

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    assign w_nf_eff = (r_nf == '0) ? NF_W'(1) :
                      ((r_nf > NF_W'(MAX_FEATURES)) ? NF_W'(MAX_FEATURES) : r_nf);
    assign w_k_eff  = (r_k == '0) ? K_W'(1) :
                      ((r_k > K_W'(MAX_K)) ? K_W'(MAX_K) : r_k);
    assign w_nc_eff = (r_nc == '0) ? NC_W'(1) :
                      ((r_nc > NC_W'(MAX_CLASSES)) ? NC_W'(MAX_CLASSES) : r_nc);
    assign w_k_last  = IDX_W'(w_k_eff - K_W'(1));
    assign w_nc_last = IDX_W'(w_nc_eff - NC_W'(1));

    // training features past the configured length do not count
    assign w_train_ok = (NF_W'(i_item.feature_index) < w_nf_eff);

    // ---------------------------------------------------------------
    // test vector memory
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept && i_item.kind == KIND_TEST) begin
            r_tv_mem[i_item.feature_index] <= i_item.feature_value;
        end
        if (w_accept && i_item.kind == KIND_TRAIN) begin
            r_tv_q <= r_tv_mem[i_item.feature_index];
        end
    end

    // ---------------------------------------------------------------
    // difference, magnitude, square
    // ---------------------------------------------------------------
    logic signed [FEAT_W:0]   w_diff;
    logic [MAG_W-1:0]         w_mag;
    logic [DIST_W:0]          w_sum;

    // |a - b| of two q8.8 values never exceeds 16 bits
    assign w_diff = {r_tv_q[FEAT_W-1], r_tv_q} - {r_val[FEAT_W-1], r_val};
    assign w_mag  = w_diff[FEAT_W] ? MAG_W'(-w_diff) : MAG_W'(w_diff);
    assign w_sum  = {1'b0, r_acc} + (DIST_W+1)'(r_sq);

    // ---------------------------------------------------------------
    // insertion: parallel compare, shift below the insertion slot
    // ---------------------------------------------------------------
    logic [MAX_K-1:0]         w_in_k;
    logic [MAX_K-1:0]         w_hit;
    logic [MAX_K-1:0]         w_before;
    logic [MAX_K-1:0]         w_prev_filled;
    logic [DIST_W-1:0]        w_prev_dist [MAX_K];
    logic [CLASS_W-1:0]       w_prev_cls  [MAX_K];

    assign w_prev_filled = {r_filled[MAX_K-2:0], 1'b0};

    always_comb begin
        for (int j = 0; j < MAX_K; j++) begin
            w_in_k[j] = (K_W'(j) < w_k_eff);
            // an empty slot takes any distance; ties keep the older sample
            w_hit[j]  = w_in_k[j] && (!r_filled[j] || (r_acc < r_dist[j]));
        end
        for (int j = 0; j < MAX_K; j++) begin
            w_before[j] = |(w_hit & ((MAX_K'(1) << j) - MAX_K'(1)));
        end
        w_prev_dist[0] = r_acc;
        w_prev_cls[0]  = i_item.sample_label;
        for (int j = 1; j < MAX_K; j++) begin
            w_prev_dist[j] = r_dist[j-1];
            w_prev_cls[j]  = r_cls[j-1];
        end
    end

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    logic [SLOT_W-1:0]        w_slot;
    logic [CLASS_W-1:0]       w_slot_cls;
    logic [CLS_W-1:0]         w_cls_idx;
    logic                     w_new_best;

    assign w_slot     = r_idx[SLOT_W-1:0];
    assign w_slot_cls = r_cls[w_slot];
    assign w_cls_idx  = r_idx[CLS_W-1:0];
    assign w_new_best = (r_vote[w_cls_idx] > r_best_n);

    always_comb begin
        n_state     = r_state;
        n_nf        = r_nf;
        n_k         = r_k;
        n_nc        = r_nc;
        n_acc       = r_acc;
        n_val       = r_val;
        n_sq        = r_sq;
        n_dist      = r_dist;
        n_cls       = r_cls;
        n_filled    = r_filled;
        n_vote      = r_vote;
        n_idx       = r_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_best_n    = r_best_n;
        n_res       = r_res;
        n_res_valid = 1'b0;

        if (w_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUM_FEATURES: n_nf = i_cfg_data;
                CFG_K_USED:       n_k  = i_cfg_data[K_W-1:0];
                CFG_NUM_CLASSES:  n_nc = i_cfg_data[NC_W-1:0];
                default:          ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_item.kind)
                        KIND_TEST: ;
                        KIND_TRAIN: begin
                            n_val = i_item.feature_value;
                            if (w_train_ok) begin
                                n_state = S_SQ;
                            end
                        end
                        KIND_END: begin
                            for (int j = 0; j < MAX_K; j++) begin
                                if (w_in_k[j] && w_before[j]) begin
                                    n_dist[j]   = w_prev_dist[j];
                                    n_cls[j]    = w_prev_cls[j];
                                    n_filled[j] = w_prev_filled[j];
                                end else if (w_hit[j]) begin
                                    n_dist[j]   = r_acc;
                                    n_cls[j]    = i_item.sample_label;
                                    n_filled[j] = 1'b1;
                                end
                            end
                            n_acc = '0;
                        end
                        KIND_CLASSIFY: begin
                            for (int c = 0; c < MAX_CLASSES; c++) begin
                                n_vote[c] = '0;
                            end
                            n_idx   = '0;
                            n_found = '0;
                            n_state = S_CNT;
                        end
                        default: ;
                    endcase
                end
            end
            S_SQ: begin
                n_sq    = w_mag * w_mag;
                n_state = S_ACC;
            end
            S_ACC: begin
                // saturate at the top of the 40-bit range
                n_acc   = w_sum[DIST_W] ? DIST_MAX : w_sum[DIST_W-1:0];
                n_state = S_IDLE;
            end
            S_CNT: begin
                if (r_filled[w_slot] && (NC_W'(w_slot_cls) < w_nc_eff)) begin
                    if (r_vote[w_slot_cls[CLS_W-1:0]] != VOTE_MAX) begin
                        n_vote[w_slot_cls[CLS_W-1:0]] =
                            r_vote[w_slot_cls[CLS_W-1:0]] + CNT_W'(1);
                    end
                    n_found = r_found + CNT_W'(1);
                end
                if (r_idx == w_k_last) begin
                    n_idx    = '0;
                    n_best   = '0;
                    n_best_n = '0;
                    n_state  = S_VOTE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_VOTE: begin
                // strict compare: the lowest class wins a tie
                if (w_new_best) begin
                    n_best   = w_cls_idx;
                    n_best_n = r_vote[w_cls_idx];
                end
                if (r_idx == w_nc_last) begin
                    n_res.predicted_class = (r_found != '0) ? CLASS_W'(n_best) : '0;
                    n_res.no_prediction   = (r_found == '0);
                    n_res.neighbors_found = r_found;
                    n_res_valid           = 1'b1;
                    n_filled              = '0;
                    for (int j = 0; j < MAX_K; j++) begin
                        n_dist[j] = DIST_MAX;
                        n_cls[j]  = '0;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nf        <= NF_W'(1);
            r_k         <= K_W'(1);
            r_nc        <= NC_W'(2);
            r_acc       <= '0;
            r_filled    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nf        <= n_nf;
            r_k         <= n_k;
            r_nc        <= n_nc;
            r_acc       <= n_acc;
            r_filled    <= n_filled;
            r_res_valid <= n_res_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_val    <= n_val;
        r_sq     <= n_sq;
        r_dist   <= n_dist;
        r_cls    <= n_cls;
        r_vote   <= n_vote;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_best   <= n_best;
        r_best_n <= n_best_n;
        r_res    <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // a result beat only follows the last step of the class scan
    `KNN_ASSERT_HOLDS(a_res_after_vote, i_clk, i_rst_n, o_res_valid, $past(r_state == S_VOTE), "result beat without a vote scan")
    // the last scan step emits a beat and leaves the list empty
    `KNN_ASSERT_NEXT(a_list_cleared, i_clk, i_rst_n, (r_state == S_VOTE) && (r_idx == w_nc_last), o_res_valid && (r_filled == '0), "classify did not clear the list")
    // filled slots always form a prefix of the list
    `KNN_ASSERT_HOLDS(a_filled_prefix, i_clk, i_rst_n, 1'b1, (r_filled & (r_filled + MAX_K'(1))) == '0, "filled slots are not contiguous")

endmodule
